// File: rtl/rbfi_pkg.sv
`timescale 1ns / 1ps
package rbfi_pkg;

   localparam int DATA_W = 32;
   localparam int FRAC_W = 16;
   localparam int TS_W   = 16;
   localparam int CFG_W  = DATA_W - 1;
   localparam int ADDR_W = 4;
   localparam int STEP_W = 6;

   localparam int DIV_MASS_STEPS = DATA_W + FRAC_W;
   localparam int DIV_KEEP_STEPS = DATA_W;

   localparam logic [CFG_W-1:0] MASS_RST     = CFG_W'(1)   << FRAC_W;
   localparam logic [CFG_W-1:0] FRICTION_RST = CFG_W'(50)  << FRAC_W;
   localparam logic [CFG_W-1:0] MAX_X_RST    = CFG_W'(200) << FRAC_W;
   localparam logic [CFG_W-1:0] MAX_Y_RST    = CFG_W'(600) << FRAC_W;

   typedef enum logic [1:0] {
      REG_MASS     = 2'd0,
      REG_FRICTION = 2'd1,
      REG_MAX_X    = 2'd2,
      REG_MAX_Y    = 2'd3
   } reg_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_DIV_GO,
      S_DIV_WAIT,
      S_ACC_MUL,
      S_VEL_UPD,
      S_FRIC,
      S_SQ_X,
      S_SQ_Y,
      S_SQ_SUM,
      S_SQRT,
      S_FR_CMP,
      S_KEEP_MUL,
      S_KEEP_GO,
      S_KEEP_WAIT,
      S_CLAMP,
      S_POS_MUL,
      S_POS_UPD,
      S_OUT
   } st_type;

   typedef struct packed {
      logic                  start;
      logic [DATA_W-1:0]     rem_init;
      logic [2*DATA_W-1:0]   num;
      logic [DATA_W-1:0]     den;
      logic [STEP_W-1:0]     steps;
   } div_req_type;

   typedef struct packed {
      logic                  busy;
      logic [2*DATA_W-1:0]   quo;
   } div_rsp_type;

   function automatic logic [DATA_W-1:0] mag(input logic signed [DATA_W-1:0] v);
      logic [DATA_W-1:0] r;
      r = v[DATA_W-1] ? (~DATA_W'(v) + DATA_W'(1)) : DATA_W'(v);
      return r;
   endfunction

   // a + (neg ? -m : m), saturated to the signed range
   function automatic logic signed [DATA_W-1:0] add_sat(
      input logic signed [DATA_W+2:0] a,
      input logic                     neg,
      input logic [DATA_W:0]          m);
      logic signed [DATA_W+2:0] d;
      logic signed [DATA_W+2:0] s;
      logic signed [DATA_W-1:0] r;
      d = neg ? -$signed({2'b00, m}) : $signed({2'b00, m});
      s = a + d;
      if (s > $signed((DATA_W+3)'({1'b0, {(DATA_W-1){1'b1}}})))
         r = {1'b0, {(DATA_W-1){1'b1}}};
      else if (s < -$signed((DATA_W+3)'({1'b1, {(DATA_W-1){1'b0}}})))
         r = {1'b1, {(DATA_W-1){1'b0}}};
      else
         r = s[DATA_W-1:0];
      return r;
   endfunction

endpackage

// File: rtl/rbfi_req_if.sv
`timescale 1ns / 1ps
interface rbfi_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [rbfi_pkg::DATA_W-1:0]  force_x;
   logic signed [rbfi_pkg::DATA_W-1:0]  force_y;
   logic signed [rbfi_pkg::DATA_W-1:0]  extra_accel_x;
   logic signed [rbfi_pkg::DATA_W-1:0]  extra_accel_y;
   logic [rbfi_pkg::TS_W-1:0]           time_step;

   modport source (output valid, force_x, force_y, extra_accel_x, extra_accel_y,
                   time_step, input ready);
   modport sink   (input valid, force_x, force_y, extra_accel_x, extra_accel_y,
                   time_step, output ready);
endinterface

// File: rtl/rbfi_rsp_if.sv
`timescale 1ns / 1ps
interface rbfi_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [rbfi_pkg::DATA_W-1:0]  new_pos_x;
   logic signed [rbfi_pkg::DATA_W-1:0]  new_pos_y;
   logic signed [rbfi_pkg::DATA_W-1:0]  new_vel_x;
   logic signed [rbfi_pkg::DATA_W-1:0]  new_vel_y;

   modport source (output valid, new_pos_x, new_pos_y, new_vel_x, new_vel_y,
                   input ready);
   modport sink   (input valid, new_pos_x, new_pos_y, new_vel_x, new_vel_y,
                   output ready);
endinterface

// File: rtl/rbfi_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle. Dividend bits enter MSB first
// from num; remainder starts at rem_init (must be below den).
module rbfi_div (
   input  logic                  clock,
   input  logic                  reset,
   input  rbfi_pkg::div_req_type req,
   output rbfi_pkg::div_rsp_type rsp
);
   localparam int W = rbfi_pkg::DATA_W;

   logic [W-1:0]                 rem_ff, rem_in;
   logic [2*W-1:0]               num_ff, num_in;
   logic [2*W-1:0]               quo_ff, quo_in;
   logic [W-1:0]                 den_ff, den_in;
   logic [rbfi_pkg::STEP_W-1:0]  cnt_ff, cnt_in;
   logic                         busy_ff, busy_in;
   logic [W:0]                   shifted;
   logic [W:0]                   diff;
   logic                         ge;

   always_comb begin
      shifted = {rem_ff, num_ff[2*W-1]};
      ge      = shifted >= {1'b0, den_ff};
      diff    = shifted - {1'b0, den_ff};
      rem_in  = rem_ff;
      num_in  = num_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (req.start) begin
         rem_in  = req.rem_init;
         num_in  = req.num;
         quo_in  = '0;
         den_in  = req.den;
         cnt_in  = req.steps;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = ge ? diff[W-1:0] : shifted[W-1:0];
         num_in  = {num_ff[2*W-2:0], 1'b0};
         quo_in  = {quo_ff[2*W-2:0], ge};
         cnt_in  = cnt_ff - rbfi_pkg::STEP_W'(1);
         busy_in = cnt_ff != rbfi_pkg::STEP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      num_ff <= num_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   assign rsp.busy = busy_ff;
   assign rsp.quo  = quo_ff;
endmodule

// File: rtl/rigid_body_friction_integrator.sv
`timescale 1ns / 1ps
// One Euler step per request, through one shared 32x32 multiplier, one
// restoring divider (one bit per cycle) and a bit-pair square root.
// Each step runs two 48-step mass divides, a 32-step root and two 32-step friction divides;
// root and friction divides are skipped if velocity is zero before friction, friction divides if friction stops it.
// Throughput: one request at a time; the next is taken once the last is done.
// Reset: synchronous; clears velocity and position, loads register defaults.
module rigid_body_friction_integrator (
   input  logic                              clock,
   input  logic                              reset,
   rbfi_req_if.sink                          req_ch,
   rbfi_rsp_if.source                        rsp_ch,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [rbfi_pkg::ADDR_W-1:0]       csr_paddr,
   input  logic [31:0]                       csr_pwdata,
   output logic [31:0]                       csr_prdata,
   output logic                              csr_pready
);
   localparam int W  = rbfi_pkg::DATA_W;
   localparam int FW = rbfi_pkg::FRAC_W;
   localparam int CW = rbfi_pkg::CFG_W;

   rbfi_pkg::st_type             state_ff, state_in;
   logic [CW-1:0]                mass_ff, mass_in;
   logic [CW-1:0]                fric_ff, fric_in;
   logic [CW-1:0]                maxx_ff, maxx_in;
   logic [CW-1:0]                maxy_ff, maxy_in;
   logic signed [W-1:0]          vx_ff, vx_in, vy_ff, vy_in;
   logic signed [W-1:0]          px_ff, px_in, py_ff, py_in;
   logic signed [W-1:0]          fx_ff, fx_in, fy_ff, fy_in;
   logic signed [W-1:0]          ex_ff, ex_in, ey_ff, ey_in;
   logic [rbfi_pkg::TS_W-1:0]    dt_ff, dt_in;
   logic signed [W-1:0]          acc_ff, acc_in;
   logic                         axis_ff, axis_in;
   logic [2*W-1:0]               prod_ff;
   logic [2*W-1:0]               sum_ff, sum_in;
   logic [CW-1:0]                fr_ff, fr_in;
   logic [2*W-1:0]               sqn_ff, sqn_in;
   logic [2*W-1:0]               res_ff, res_in;
   logic [2*W-1:0]               bit_ff, bit_in;
   logic [W-1:0]                 keep_ff, keep_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [W-1:0]          opx_ff, opx_in, opy_ff, opy_in;
   logic signed [W-1:0]          ovx_ff, ovx_in, ovy_ff, ovy_in;

   logic [W-1:0]                 mul_a, mul_b;
   rbfi_pkg::div_req_type        div_req;
   rbfi_pkg::div_rsp_type        div_rsp;

   logic signed [W-1:0]          f_cur, e_cur, v_cur, p_cur;
   logic [W-1:0]                 f_mag;
   logic [W:0]                   q_cap;
   logic [2*W-1:0]               sq_t;
   logic [W-1:0]                 speed;
   logic signed [W:0]            limx, limy;
   logic                         csr_wr;

   rbfi_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      case (rbfi_pkg::reg_type'(csr_paddr[3:2]))
         rbfi_pkg::REG_MASS:     csr_prdata = {1'b0, mass_ff};
         rbfi_pkg::REG_FRICTION: csr_prdata = {1'b0, fric_ff};
         rbfi_pkg::REG_MAX_X:    csr_prdata = {1'b0, maxx_ff};
         rbfi_pkg::REG_MAX_Y:    csr_prdata = {1'b0, maxy_ff};
         default:                csr_prdata = '0;
      endcase
   end

   assign req_ch.ready     = state_ff == rbfi_pkg::S_IDLE;
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.new_pos_x = opx_ff;
   assign rsp_ch.new_pos_y = opy_ff;
   assign rsp_ch.new_vel_x = ovx_ff;
   assign rsp_ch.new_vel_y = ovy_ff;

   always_comb begin
      f_cur = axis_ff ? fy_ff : fx_ff;
      e_cur = axis_ff ? ey_ff : ex_ff;
      v_cur = axis_ff ? vy_ff : vx_ff;
      p_cur = axis_ff ? py_ff : px_ff;
      f_mag = rbfi_pkg::mag(f_cur);
      // force/mass magnitude caps at 2^W
      q_cap = (div_rsp.quo > (2*W)'({1'b1, {W{1'b0}}})) ? {1'b1, {W{1'b0}}}
                                                       : div_rsp.quo[W:0];
      sq_t  = res_ff + bit_ff;
      speed = res_ff[W-1:0];
      limx  = $signed({2'b00, maxx_ff});
      limy  = $signed({2'b00, maxy_ff});

      state_in     = state_ff;
      mass_in      = mass_ff;
      fric_in      = fric_ff;
      maxx_in      = maxx_ff;
      maxy_in      = maxy_ff;
      vx_in        = vx_ff;
      vy_in        = vy_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      fx_in        = fx_ff;
      fy_in        = fy_ff;
      ex_in        = ex_ff;
      ey_in        = ey_ff;
      dt_in        = dt_ff;
      acc_in       = acc_ff;
      axis_in      = axis_ff;
      sum_in       = sum_ff;
      fr_in        = fr_ff;
      sqn_in       = sqn_ff;
      res_in       = res_ff;
      bit_in       = bit_ff;
      keep_in      = keep_ff;
      rsp_valid_in = rsp_valid_ff;
      opx_in       = opx_ff;
      opy_in       = opy_ff;
      ovx_in       = ovx_ff;
      ovy_in       = ovy_ff;
      mul_a        = '0;
      mul_b        = '0;
      div_req      = '0;

      if (csr_wr) begin
         case (rbfi_pkg::reg_type'(csr_paddr[3:2]))
            rbfi_pkg::REG_MASS:     mass_in = csr_pwdata[CW-1:0];
            rbfi_pkg::REG_FRICTION: fric_in = csr_pwdata[CW-1:0];
            rbfi_pkg::REG_MAX_X:    maxx_in = csr_pwdata[CW-1:0];
            rbfi_pkg::REG_MAX_Y:    maxy_in = csr_pwdata[CW-1:0];
            default:                mass_in = mass_ff;
         endcase
      end

      if (rsp_valid_ff && rsp_ch.ready) rsp_valid_in = 1'b0;

      case (state_ff)
         rbfi_pkg::S_IDLE: begin
            if (req_ch.valid) begin
               fx_in    = req_ch.force_x;
               fy_in    = req_ch.force_y;
               ex_in    = req_ch.extra_accel_x;
               ey_in    = req_ch.extra_accel_y;
               dt_in    = req_ch.time_step;
               axis_in  = 1'b0;
               state_in = rbfi_pkg::S_DIV_GO;
            end
         end
         rbfi_pkg::S_DIV_GO: begin
            div_req.start    = 1'b1;
            div_req.rem_init = '0;
            div_req.num      = {f_mag, {W{1'b0}}};
            div_req.den      = {1'b0, mass_ff};
            div_req.steps    = rbfi_pkg::STEP_W'(rbfi_pkg::DIV_MASS_STEPS);
            state_in         = rbfi_pkg::S_DIV_WAIT;
         end
         rbfi_pkg::S_DIV_WAIT: begin
            if (!div_rsp.busy) begin
               acc_in = rbfi_pkg::add_sat(
                  (W+3)'(e_cur), f_cur[W-1], (f_mag == '0) ? '0 : q_cap);
               state_in = rbfi_pkg::S_ACC_MUL;
            end
         end
         rbfi_pkg::S_ACC_MUL: begin
            mul_a    = rbfi_pkg::mag(acc_ff);
            mul_b    = W'(dt_ff);
            state_in = rbfi_pkg::S_VEL_UPD;
         end
         rbfi_pkg::S_VEL_UPD: begin
            if (axis_ff) begin
               vy_in    = rbfi_pkg::add_sat((W+3)'(vy_ff), acc_ff[W-1],
                                            {1'b0, prod_ff[W+FW-1:FW]});
               axis_in  = 1'b0;
               state_in = rbfi_pkg::S_FRIC;
            end else begin
               vx_in    = rbfi_pkg::add_sat((W+3)'(vx_ff), acc_ff[W-1],
                                            {1'b0, prod_ff[W+FW-1:FW]});
               axis_in  = 1'b1;
               state_in = rbfi_pkg::S_DIV_GO;
            end
         end
         rbfi_pkg::S_FRIC: begin
            mul_a    = {1'b0, fric_ff};
            mul_b    = W'(dt_ff);
            state_in = (vx_ff == '0 && vy_ff == '0) ? rbfi_pkg::S_CLAMP
                                                    : rbfi_pkg::S_SQ_X;
         end
         rbfi_pkg::S_SQ_X: begin
            fr_in    = prod_ff[CW+FW-1:FW];
            mul_a    = rbfi_pkg::mag(vx_ff);
            mul_b    = rbfi_pkg::mag(vx_ff);
            state_in = rbfi_pkg::S_SQ_Y;
         end
         rbfi_pkg::S_SQ_Y: begin
            sum_in   = prod_ff;
            mul_a    = rbfi_pkg::mag(vy_ff);
            mul_b    = rbfi_pkg::mag(vy_ff);
            state_in = rbfi_pkg::S_SQ_SUM;
         end
         rbfi_pkg::S_SQ_SUM: begin
            sqn_in   = sum_ff + prod_ff;
            res_in   = '0;
            bit_in   = (2*W)'(1) << (2*W-2);
            state_in = rbfi_pkg::S_SQRT;
         end
         rbfi_pkg::S_SQRT: begin
            if (sqn_ff >= sq_t) begin
               sqn_in = sqn_ff - sq_t;
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            if (bit_ff[0]) state_in = rbfi_pkg::S_FR_CMP;
         end
         rbfi_pkg::S_FR_CMP: begin
            if ({1'b0, fr_ff} >= speed) begin
               vx_in    = '0;
               vy_in    = '0;
               state_in = rbfi_pkg::S_CLAMP;
            end else begin
               keep_in  = speed - {1'b0, fr_ff};
               axis_in  = 1'b0;
               state_in = rbfi_pkg::S_KEEP_MUL;
            end
         end
         rbfi_pkg::S_KEEP_MUL: begin
            mul_a    = rbfi_pkg::mag(v_cur);
            mul_b    = keep_ff;
            state_in = rbfi_pkg::S_KEEP_GO;
         end
         rbfi_pkg::S_KEEP_GO: begin
            // quotient stays below |v|, so the high half is already a remainder
            div_req.start    = 1'b1;
            div_req.rem_init = prod_ff[2*W-1:W];
            div_req.num      = {prod_ff[W-1:0], {W{1'b0}}};
            div_req.den      = speed;
            div_req.steps    = rbfi_pkg::STEP_W'(rbfi_pkg::DIV_KEEP_STEPS);
            state_in         = rbfi_pkg::S_KEEP_WAIT;
         end
         rbfi_pkg::S_KEEP_WAIT: begin
            if (!div_rsp.busy) begin
               if (axis_ff) begin
                  vy_in    = v_cur[W-1] ? -$signed(div_rsp.quo[W-1:0])
                                        : $signed(div_rsp.quo[W-1:0]);
                  axis_in  = 1'b0;
                  state_in = rbfi_pkg::S_CLAMP;
               end else begin
                  vx_in    = v_cur[W-1] ? -$signed(div_rsp.quo[W-1:0])
                                        : $signed(div_rsp.quo[W-1:0]);
                  axis_in  = 1'b1;
                  state_in = rbfi_pkg::S_KEEP_MUL;
               end
            end
         end
         rbfi_pkg::S_CLAMP: begin
            if ((W+1)'(vx_ff) > limx)       vx_in = limx[W-1:0];
            else if ((W+1)'(vx_ff) < -limx) vx_in = W'(-limx);
            if ((W+1)'(vy_ff) > limy)       vy_in = limy[W-1:0];
            else if ((W+1)'(vy_ff) < -limy) vy_in = W'(-limy);
            axis_in  = 1'b0;
            state_in = rbfi_pkg::S_POS_MUL;
         end
         rbfi_pkg::S_POS_MUL: begin
            mul_a    = rbfi_pkg::mag(v_cur);
            mul_b    = W'(dt_ff);
            state_in = rbfi_pkg::S_POS_UPD;
         end
         rbfi_pkg::S_POS_UPD: begin
            if (axis_ff) begin
               py_in    = rbfi_pkg::add_sat((W+3)'(p_cur), v_cur[W-1],
                                            {1'b0, prod_ff[W+FW-1:FW]});
               state_in = rbfi_pkg::S_OUT;
            end else begin
               px_in    = rbfi_pkg::add_sat((W+3)'(p_cur), v_cur[W-1],
                                            {1'b0, prod_ff[W+FW-1:FW]});
               axis_in  = 1'b1;
               state_in = rbfi_pkg::S_POS_MUL;
            end
         end
         rbfi_pkg::S_OUT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               opx_in       = px_ff;
               opy_in       = py_ff;
               ovx_in       = vx_ff;
               ovy_in       = vy_ff;
               state_in     = rbfi_pkg::S_IDLE;
            end
         end
         default: state_in = rbfi_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      fx_ff   <= fx_in;
      fy_ff   <= fy_in;
      ex_ff   <= ex_in;
      ey_ff   <= ey_in;
      dt_ff   <= dt_in;
      acc_ff  <= acc_in;
      prod_ff <= mul_a * mul_b;
      sum_ff  <= sum_in;
      fr_ff   <= fr_in;
      sqn_ff  <= sqn_in;
      res_ff  <= res_in;
      bit_ff  <= bit_in;
      keep_ff <= keep_in;
      opx_ff  <= opx_in;
      opy_ff  <= opy_in;
      ovx_ff  <= ovx_in;
      ovy_ff  <= ovy_in;
      if (reset) begin
         state_ff     <= rbfi_pkg::S_IDLE;
         mass_ff      <= rbfi_pkg::MASS_RST;
         fric_ff      <= rbfi_pkg::FRICTION_RST;
         maxx_ff      <= rbfi_pkg::MAX_X_RST;
         maxy_ff      <= rbfi_pkg::MAX_Y_RST;
         vx_ff        <= '0;
         vy_ff        <= '0;
         px_ff        <= '0;
         py_ff        <= '0;
         axis_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mass_ff      <= mass_in;
         fric_ff      <= fric_in;
         maxx_ff      <= maxx_in;
         maxy_ff      <= maxy_in;
         vx_ff        <= vx_in;
         vy_ff        <= vy_in;
         px_ff        <= px_in;
         py_ff        <= py_in;
         axis_ff      <= axis_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule

// File: rtl/rbfi_check.sv
`timescale 1ns / 1ps
module rbfi_check (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [rbfi_pkg::DATA_W-1:0]   rsp_new_pos_x,
   input logic [rbfi_pkg::DATA_W-1:0]   rsp_new_vel_y
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_new_pos_x) && $stable(rsp_new_vel_y))
      else $error("stalled response changed");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid |=> !rsp_valid)
      else $error("response too early after request");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");
endmodule

bind rigid_body_friction_integrator rbfi_check u_rbfi_check (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_new_pos_x (rsp_ch.new_pos_x),
   .rsp_new_vel_y (rsp_ch.new_vel_y)
);

// File: tb/tb_rigid_body_friction_integrator.sv
`timescale 1ns / 1ps
module tb_rigid_body_friction_integrator;

   localparam int DATA_W = rbfi_pkg::DATA_W;
   localparam int FRAC_W = rbfi_pkg::FRAC_W;
   localparam int TS_W   = rbfi_pkg::TS_W;
   localparam int CFG_W  = rbfi_pkg::CFG_W;
   localparam int ADDR_W = rbfi_pkg::ADDR_W;

   typedef struct {
      logic signed [DATA_W-1:0] force_x;
      logic signed [DATA_W-1:0] force_y;
      logic signed [DATA_W-1:0] extra_accel_x;
      logic signed [DATA_W-1:0] extra_accel_y;
      logic [TS_W-1:0]          time_step;
   } step_req_type;

   typedef struct {
      logic signed [DATA_W-1:0] pos_x;
      logic signed [DATA_W-1:0] pos_y;
      logic signed [DATA_W-1:0] vel_x;
      logic signed [DATA_W-1:0] vel_y;
   } body_state_type;

   localparam longint SAT_HI = 64'sd2147483647;
   localparam longint SAT_LO = -64'sd2147483648;
   localparam logic [CFG_W-1:0] CFG_MAX = {CFG_W{1'b1}};
   localparam int SETTLE_CYCLES = 300;

   logic clock = 1'b0;
   logic reset;
   logic csr_psel, csr_penable, csr_pwrite;
   logic [ADDR_W-1:0] csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;
   logic csr_pready;

   rbfi_req_if req_ch ();
   rbfi_rsp_if rsp_ch ();

   rigid_body_friction_integrator DUT (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // predictor copy of body state and registers
   longint unsigned mass_q, fric_q, lim_x, lim_y;
   longint vel_x, vel_y, pos_x, pos_y;

   step_req_type   pending_steps[$];
   body_state_type expected_states[$];
   int errors = 0;
   int n_accepted = 0;
   int n_checked = 0;
   int n_writes = 0;
   bit hold_sender = 1'b0;
   bit req_taken = 1'b0;
   bit long_stall_req = 1'b0;
   int long_stalls_done = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic longint sat_w(longint x);
      if (x > SAT_HI) return SAT_HI;
      if (x < SAT_LO) return SAT_LO;
      return x;
   endfunction

   function automatic longint unsigned abs_w(longint v);
      return (v < 0) ? longint'(-v) : longint'(v);
   endfunction

   function automatic longint apply_sign(bit neg, longint unsigned m);
      return neg ? -longint'(m) : longint'(m);
   endfunction

   function automatic longint times_dt(longint v, longint unsigned dt);
      longint unsigned p;
      p = (abs_w(v) * dt) >> TS_W;
      return apply_sign(v < 0, p);
   endfunction

   function automatic longint force_over_mass(longint f, longint unsigned m);
      longint unsigned cap, a, q, r;
      cap = 64'd1 << DATA_W;
      a = abs_w(f);
      if (a == 0) return 0;
      if (m == 0) return apply_sign(f < 0, cap);
      q = a / m;
      r = a % m;
      for (int i = 0; i < FRAC_W && q < cap; i++) begin
         r = r << 1;
         q = q << 1;
         if (r >= m) begin
            r = r - m;
            q = q | 64'd1;
         end
      end
      if (q > cap) q = cap;
      return apply_sign(f < 0, q);
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= res + b) begin
            n = n - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   // floor(a * b / c), b < c
   function automatic longint unsigned scale_ratio(longint unsigned a, longint unsigned b,
                                                   longint unsigned c);
      longint unsigned q, r;
      q = 0;
      r = 0;
      for (int i = 49; i >= 0; i--) begin
         q = q << 1;
         r = r << 1;
         if (b[i]) r = r + a;
         q = q + r / c;
         r = r % c;
      end
      return q;
   endfunction

   function automatic longint clamp_mag(longint v, longint unsigned lim);
      longint l;
      l = longint'(lim);
      if (v > l) return l;
      if (v < -l) return -l;
      return v;
   endfunction

   function automatic body_state_type euler_step(step_req_type s);
      longint ax, ay;
      longint unsigned dt, fr, mx, my, spd, keep;
      body_state_type o;
      dt = s.time_step;
      ax = sat_w(force_over_mass(longint'(s.force_x), mass_q) + longint'(s.extra_accel_x));
      ay = sat_w(force_over_mass(longint'(s.force_y), mass_q) + longint'(s.extra_accel_y));
      vel_x = sat_w(vel_x + times_dt(ax, dt));
      vel_y = sat_w(vel_y + times_dt(ay, dt));
      if (vel_x != 0 || vel_y != 0) begin
         fr = (fric_q * dt) >> TS_W;
         mx = abs_w(vel_x);
         my = abs_w(vel_y);
         spd = int_sqrt(mx * mx + my * my);
         if (fr >= spd) begin
            vel_x = 0;
            vel_y = 0;
         end else begin
            keep = spd - fr;
            vel_x = sat_w(apply_sign(vel_x < 0, scale_ratio(mx, keep, spd)));
            vel_y = sat_w(apply_sign(vel_y < 0, scale_ratio(my, keep, spd)));
         end
      end
      vel_x = clamp_mag(vel_x, lim_x);
      vel_y = clamp_mag(vel_y, lim_y);
      pos_x = sat_w(pos_x + times_dt(vel_x, dt));
      pos_y = sat_w(pos_y + times_dt(vel_y, dt));
      o.pos_x = pos_x[DATA_W-1:0];
      o.pos_y = pos_y[DATA_W-1:0];
      o.vel_x = vel_x[DATA_W-1:0];
      o.vel_y = vel_y[DATA_W-1:0];
      return o;
   endfunction

   function automatic logic signed [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         2: return 0;
         3, 4: return $urandom;
         default: return $signed($urandom_range(0, 32'h003fffff)) - 32'sh00200000;
      endcase
   endfunction

   function automatic logic [TS_W-1:0] pick_dt();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return 16'hffff;
         2, 3: return TS_W'($urandom_range(0, 16'hffff));
         default: return TS_W'($urandom_range(256, 4096));
      endcase
   endfunction

   task automatic queue_step(logic signed [DATA_W-1:0] fx, logic signed [DATA_W-1:0] fy,
                             logic signed [DATA_W-1:0] ex, logic signed [DATA_W-1:0] ey,
                             logic [TS_W-1:0] dt);
      step_req_type s;
      s.force_x = fx;
      s.force_y = fy;
      s.extra_accel_x = ex;
      s.extra_accel_y = ey;
      s.time_step = dt;
      pending_steps.push_back(s);
   endtask

   task automatic queue_random(int n);
      for (int i = 0; i < n; i++)
         queue_step(pick_value(), pick_value(), pick_value(), pick_value(), pick_dt());
   endtask

   task automatic wait_idle();
      while (pending_steps.size() != 0 || req_ch.valid || expected_states.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(rbfi_pkg::reg_type r, logic [CFG_W-1:0] v);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= ADDR_W'(r) << 2;
      csr_pwdata <= {1'b0, v};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (r)
         rbfi_pkg::REG_MASS:     mass_q = v;
         rbfi_pkg::REG_FRICTION: fric_q = v;
         rbfi_pkg::REG_MAX_X:    lim_x = v;
         rbfi_pkg::REG_MAX_Y:    lim_y = v;
         default:                mass_q = mass_q;
      endcase
      n_writes++;
   endtask

   task automatic set_regs(logic [CFG_W-1:0] m, logic [CFG_W-1:0] f,
                           logic [CFG_W-1:0] lx, logic [CFG_W-1:0] ly);
      csr_write(rbfi_pkg::REG_MASS, m);
      csr_write(rbfi_pkg::REG_FRICTION, f);
      csr_write(rbfi_pkg::REG_MAX_X, lx);
      csr_write(rbfi_pkg::REG_MAX_Y, ly);
   endtask

   // sender: bursts and gaps
   int burst_left = 0;
   int gap_left = 0;
   always @(negedge clock) begin
      step_req_type s;
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.force_x <= '0;
         req_ch.force_y <= '0;
         req_ch.extra_accel_x <= '0;
         req_ch.extra_accel_y <= '0;
         req_ch.time_step <= '0;
      end else if (!req_ch.valid || req_taken) begin
         if (gap_left > 0) begin
            gap_left--;
            req_ch.valid <= 1'b0;
         end else if (hold_sender || pending_steps.size() == 0) begin
            req_ch.valid <= 1'b0;
         end else begin
            s = pending_steps.pop_front();
            req_ch.force_x <= s.force_x;
            req_ch.force_y <= s.force_y;
            req_ch.extra_accel_x <= s.extra_accel_x;
            req_ch.extra_accel_y <= s.extra_accel_y;
            req_ch.time_step <= s.time_step;
            req_ch.valid <= 1'b1;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 12);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 400);
            end
         end
      end
   end

   // receiver: stall pattern redrawn whenever mode_cnt runs out; long hold-off on demand
   int ready_mode = 0;
   int mode_cnt = 0;
   int hold_cnt = 0;
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_cnt > 0) begin
         hold_cnt--;
         rsp_ch.ready <= 1'b0;
      end else if (long_stall_req) begin
         long_stall_req = 1'b0;
         hold_cnt = 1500;
         long_stalls_done++;
         rsp_ch.ready <= 1'b0;
      end else begin
         if (mode_cnt == 0) begin
            ready_mode = $urandom_range(0, 3);
            mode_cnt = 50;
         end
         mode_cnt--;
         case (ready_mode)
            0: rsp_ch.ready <= 1'b1;
            1: rsp_ch.ready <= 1'($urandom_range(0, 1));
            2: rsp_ch.ready <= ($urandom_range(0, 7) == 0);
            default: rsp_ch.ready <= ($urandom_range(0, 9) != 0);
         endcase
      end
   end

   // monitor: check results, then predict accepted requests
   always @(posedge clock) begin
      body_state_type e;
      step_req_type s;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_states.size() == 0) begin
               errors++;
               $display("%0t: unexpected result pos %0d,%0d vel %0d,%0d", $time,
                        rsp_ch.new_pos_x, rsp_ch.new_pos_y, rsp_ch.new_vel_x,
                        rsp_ch.new_vel_y);
            end else begin
               e = expected_states.pop_front();
               n_checked++;
               if (rsp_ch.new_pos_x !== e.pos_x) begin
                  errors++;
                  $display("%0t: new_pos_x expected %0d got %0d", $time, e.pos_x,
                           rsp_ch.new_pos_x);
               end
               if (rsp_ch.new_pos_y !== e.pos_y) begin
                  errors++;
                  $display("%0t: new_pos_y expected %0d got %0d", $time, e.pos_y,
                           rsp_ch.new_pos_y);
               end
               if (rsp_ch.new_vel_x !== e.vel_x) begin
                  errors++;
                  $display("%0t: new_vel_x expected %0d got %0d", $time, e.vel_x,
                           rsp_ch.new_vel_x);
               end
               if (rsp_ch.new_vel_y !== e.vel_y) begin
                  errors++;
                  $display("%0t: new_vel_y expected %0d got %0d", $time, e.vel_y,
                           rsp_ch.new_vel_y);
               end
            end
         end
         req_taken = req_ch.valid && req_ch.ready;
         if (req_taken) begin
            s.force_x = req_ch.force_x;
            s.force_y = req_ch.force_y;
            s.extra_accel_x = req_ch.extra_accel_x;
            s.extra_accel_y = req_ch.extra_accel_y;
            s.time_step = req_ch.time_step;
            expected_states.push_back(euler_step(s));
            n_accepted++;
         end
      end
   end

   initial begin
      #40ms;
      $display("** rigid_body_friction_integrator: FAILED **");
      $finish;
   end

   initial begin
      reset = 1'b1;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      mass_q = rbfi_pkg::MASS_RST;
      fric_q = rbfi_pkg::FRICTION_RST;
      lim_x = rbfi_pkg::MAX_X_RST;
      lim_y = rbfi_pkg::MAX_Y_RST;
      vel_x = 0;
      vel_y = 0;
      pos_x = 0;
      pos_y = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // defaults: zero step, extremes, saturation, friction cases
      queue_step(0, 0, 0, 0, 16'h0000);
      queue_step(0, 0, 0, 0, 16'hffff);
      queue_step(32'sh7fffffff, 32'sh7fffffff, 0, 0, 16'hffff);
      queue_step(32'sh80000000, 32'sh80000000, 0, 0, 16'hffff);
      queue_step(0, 0, 32'sh7fffffff, 32'sh80000000, 16'hffff);
      queue_step(0, 0, 32'sh80000000, 32'sh7fffffff, 16'h8000);
      queue_step(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 16'hffff);
      queue_step(32'sh00010000, 0, 0, 0, 16'h0000);
      queue_step(0, 0, 0, -32'sh00098000, 16'h0444);
      queue_step(0, 0, 0, -32'sh00098000, 16'h0444);
      queue_step(32'sh00640000, 32'sh00320000, 0, 0, 16'h1000);
      queue_step(32'sh00000001, 32'shffffffff, 0, 0, 16'h0001);
      queue_step(0, 0, 0, 0, 16'h0100);
      queue_step(32'sh12345678, 32'shedcba987, 32'sh55555555, 32'shaaaaaaaa, 16'h5a5a);
      queue_step(0, 0, 0, 0, 16'hffff);
      wait_idle();

      // tiny mass, no friction, no limits: drives saturation
      set_regs(CFG_W'(1), CFG_W'(0), CFG_MAX, CFG_MAX);
      queue_random(200);
      wait_idle();

      // heavy body, huge friction, zero limits
      set_regs(CFG_MAX, CFG_MAX, CFG_W'(0), CFG_W'(0));
      queue_random(200);
      wait_idle();

      // random registers, receiver holds off while requests keep coming
      set_regs(CFG_W'($urandom_range(1, CFG_MAX)), CFG_W'($urandom_range(0, 32'h00ffffff)),
               CFG_W'($urandom_range(0, CFG_MAX)), CFG_W'($urandom_range(0, 32'h0fffffff)));
      long_stall_req = 1'b1;
      queue_random(200);
      wait_idle();

      set_regs(CFG_W'(32'h00010000), CFG_W'($urandom_range(0, 32'h000fffff)),
               CFG_W'($urandom_range(32'h00010000, 32'h0fffffff)),
               CFG_W'($urandom_range(32'h00010000, 32'h0fffffff)));
      queue_random(220);
      wait_idle();

      // sender held off while requests queue up
      set_regs(CFG_W'($urandom_range(32'h00001000, 32'h01000000)),
               CFG_W'($urandom_range(0, 32'h00400000)),
               CFG_W'($urandom_range(0, CFG_MAX)), CFG_W'($urandom_range(0, CFG_MAX)));
      queue_random(100);
      wait_idle();
      hold_sender = 1'b1;
      queue_random(100);
      repeat (50) @(posedge clock);
      hold_sender = 1'b0;
      wait_idle();

      set_regs(rbfi_pkg::MASS_RST, rbfi_pkg::FRICTION_RST, rbfi_pkg::MAX_X_RST,
               rbfi_pkg::MAX_Y_RST);
      queue_random(200);
      wait_idle();

      $display("covered %0d steps, %0d results checked, %0d register writes, %0d long hold-offs",
               n_accepted, n_checked, n_writes, long_stalls_done);
      $display("register sets included unit-lsb mass, max mass and friction, zero and max limits");
      if (errors == 0)
         $display("** rigid_body_friction_integrator: PASSED **");
      else
         $display("** rigid_body_friction_integrator: FAILED **");
      $finish;
   end

endmodule
